@@ hdl/cache_op_message_parser_macros.svh @@
// Assertion macros used by the message parser front end (cop_front).
// Depends on the clock i_clk and the reset i_rst_n being in scope where used.
`ifndef CACHE_OP_MESSAGE_PARSER_MACROS_SVH
`define CACHE_OP_MESSAGE_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define COP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("message parser assertion failed");

// Next-cycle implication, disabled during reset.
`define COP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("message parser assertion failed");

`endif

@@ hdl/cop_pkg.sv @@
// Package of the cache operation message parser: constants, codes and types.
// Used by every module of the block; depends on nothing.
package cop_pkg;

    localparam int MinBytes  = 21;
    localparam int OpidBytes = 8;
    localparam int NodeBytes = 4;
    localparam int KlenBytes = 2;
    localparam int VlenBytes = 4;

    localparam int AddrWidth = 3;
    localparam int DataWidth = 32;

    localparam logic RegExpectedVersion = 1'b0;
    localparam logic RegTombstoneMask   = 1'b1;

    localparam logic [7:0] ExpectedVersionReset = 8'd1;
    localparam logic [7:0] TombstoneMaskReset   = 8'd1;

    localparam logic [1:0] SegNone  = 2'd0;
    localparam logic [1:0] SegTopic = 2'd1;
    localparam logic [1:0] SegKey   = 2'd2;
    localparam logic [1:0] SegValue = 2'd3;

    localparam logic [1:0] StOk         = 2'd0;
    localparam logic [1:0] StTooShort   = 2'd1;
    localparam logic [1:0] StBadVersion = 2'd2;
    localparam logic [1:0] StTruncated  = 2'd3;

    typedef enum logic [10:0] {
        PH_VERSION = 11'b000_0000_0001,
        PH_FLAGS   = 11'b000_0000_0010,
        PH_OPID    = 11'b000_0000_0100,
        PH_NODE    = 11'b000_0000_1000,
        PH_TLEN    = 11'b000_0001_0000,
        PH_TOPIC   = 11'b000_0010_0000,
        PH_KLEN    = 11'b000_0100_0000,
        PH_KEY     = 11'b000_1000_0000,
        PH_VLEN    = 11'b001_0000_0000,
        PH_VALUE   = 11'b010_0000_0000,
        PH_TRAIL   = 11'b100_0000_0000
    } t_phase;

    typedef enum logic [2:0] {
        KIND_OTHER = 3'd0,
        KIND_FLAGS = 3'd1,
        KIND_OPID  = 3'd2,
        KIND_NODE  = 3'd3,
        KIND_TLEN  = 3'd4,
        KIND_KLEN  = 3'd5,
        KIND_VLEN  = 3'd6
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        t_kind      kind;
        logic [1:0] segment;
        logic       last;
        logic [1:0] status;
    } t_item;

endpackage

@@ hdl/cop_front.sv @@
// Front end of the message parser: accepts bytes, tracks the field layout and classifies each item.
// Depends on cop_pkg and cache_op_message_parser_macros.svh.
`include "cache_op_message_parser_macros.svh"

module cop_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_message,
    input  logic [7:0]    i_expected_version,
    input  logic          i_full,
    output logic          o_push,
    output cop_pkg::t_item o_item
);
    import cop_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_acc, n_acc;
    logic [4:0]  r_seen, n_seen;
    logic        r_vbad, n_vbad;
    logic        accept;
    logic [31:0] rem_dec;
    logic [15:0] acc_k;
    logic [31:0] acc_v;
    logic [1:0]  seg;
    t_kind       kind;
    logic [1:0]  status;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;
    assign rem_dec = r_rem - 32'd1;
    assign acc_k   = {r_acc[7:0], i_data_byte};
    assign acc_v   = {r_acc[23:0], i_data_byte};

    always_comb begin
        n_phase = r_phase;
        n_rem   = r_rem;
        n_acc   = r_acc;
        n_vbad  = r_vbad;
        seg     = SegNone;
        kind    = KIND_OTHER;
        unique case (r_phase)
            PH_VERSION: begin
                n_vbad  = (i_data_byte != i_expected_version);
                n_phase = PH_FLAGS;
            end
            PH_FLAGS: begin
                kind    = KIND_FLAGS;
                n_phase = PH_OPID;
                n_rem   = 32'(OpidBytes);
            end
            PH_OPID: begin
                kind  = KIND_OPID;
                n_rem = rem_dec;
                if (rem_dec == 32'd0) begin
                    n_phase = PH_NODE;
                    n_rem   = 32'(NodeBytes);
                end
            end
            PH_NODE: begin
                kind  = KIND_NODE;
                n_rem = rem_dec;
                if (rem_dec == 32'd0) begin
                    n_phase = PH_TLEN;
                end
            end
            PH_TLEN: begin
                kind  = KIND_TLEN;
                n_acc = 32'd0;
                if (i_data_byte == 8'd0) begin
                    n_phase = PH_KLEN;
                    n_rem   = 32'(KlenBytes);
                end else begin
                    n_phase = PH_TOPIC;
                    n_rem   = {24'd0, i_data_byte};
                end
            end
            PH_TOPIC: begin
                seg   = SegTopic;
                n_rem = rem_dec;
                if (rem_dec == 32'd0) begin
                    n_phase = PH_KLEN;
                    n_rem   = 32'(KlenBytes);
                end
            end
            PH_KLEN: begin
                kind  = KIND_KLEN;
                n_rem = rem_dec;
                n_acc = {16'd0, acc_k};
                if (rem_dec == 32'd0) begin
                    if (acc_k == 16'd0) begin
                        n_phase = PH_VLEN;
                        n_rem   = 32'(VlenBytes);
                        n_acc   = 32'd0;
                    end else begin
                        n_phase = PH_KEY;
                        n_rem   = {16'd0, acc_k};
                    end
                end
            end
            PH_KEY: begin
                seg   = SegKey;
                n_rem = rem_dec;
                if (rem_dec == 32'd0) begin
                    n_phase = PH_VLEN;
                    n_rem   = 32'(VlenBytes);
                    n_acc   = 32'd0;
                end
            end
            PH_VLEN: begin
                kind  = KIND_VLEN;
                n_rem = rem_dec;
                n_acc = acc_v;
                if (rem_dec == 32'd0) begin
                    if (acc_v == 32'd0) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        n_phase = PH_VALUE;
                        n_rem   = acc_v;
                    end
                end
            end
            PH_VALUE: begin
                seg   = SegValue;
                n_rem = rem_dec;
                if (rem_dec == 32'd0) begin
                    n_phase = PH_TRAIL;
                end
            end
            default: begin
            end
        endcase

        n_seen = (r_seen < 5'(MinBytes)) ? r_seen + 5'd1 : r_seen;

        if (n_seen < 5'(MinBytes)) begin
            status = StTooShort;
        end else if (n_vbad) begin
            status = StBadVersion;
        end else if (n_phase != PH_TRAIL) begin
            status = StTruncated;
        end else begin
            status = StOk;
        end

        o_item.data_byte = i_data_byte;
        o_item.kind      = kind;
        o_item.segment   = n_vbad ? SegNone : seg;
        o_item.last      = i_end_of_message;
        o_item.status    = i_end_of_message ? status : StOk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_VERSION;
            r_rem   <= 32'd0;
            r_acc   <= 32'd0;
            r_seen  <= 5'd0;
            r_vbad  <= 1'b0;
        end else if (accept) begin
            if (i_end_of_message) begin
                r_phase <= PH_VERSION;
                r_rem   <= 32'd0;
                r_acc   <= 32'd0;
                r_seen  <= 5'd0;
                r_vbad  <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_rem   <= n_rem;
                r_acc   <= n_acc;
                r_seen  <= n_seen;
                r_vbad  <= n_vbad;
            end
        end
    end

    `COP_ASSERT_IMP(a_seen_saturates, 1'b1, r_seen <= 5'(MinBytes))
    `COP_ASSERT_NEXT(a_last_clears, accept && i_end_of_message, r_phase == PH_VERSION && r_seen == 5'd0)
    `COP_ASSERT_IMP(a_vbad_after_version, r_vbad, r_phase != PH_VERSION)

endmodule

@@ hdl/cop_queue.sv @@
// Two-entry item queue between the front end and the back end of the message parser.
// Depends on cop_pkg.
module cop_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cop_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output cop_pkg::t_item o_item
);
    import cop_pkg::*;

    t_item      r_slot [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

@@ hdl/cop_back.sv @@
// Back end of the message parser: assembles header fields and lengths and drives the result register.
// Depends on cop_pkg.
module cop_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    input  cop_pkg::t_item i_item,
    output logic           o_take,
    input  logic [7:0]     i_tombstone_mask,
    input  logic           i_stall,
    output logic           o_valid,
    output logic [1:0]     o_segment,
    output logic [7:0]     o_payload_byte,
    output logic           o_payload_valid,
    output logic           o_message_done,
    output logic [1:0]     o_status,
    output logic [63:0]    o_operation_id,
    output logic [31:0]    o_node_number,
    output logic           o_tombstone,
    output logic [7:0]     o_topic_length,
    output logic [15:0]    o_key_length,
    output logic [31:0]    o_value_length
);
    import cop_pkg::*;

    logic [63:0] r_id, n_id;
    logic [31:0] r_node, n_node;
    logic [7:0]  r_flags, n_flags;
    logic [7:0]  r_tlen, n_tlen;
    logic [15:0] r_klen, n_klen;
    logic [31:0] r_vlen, n_vlen;
    logic        r_out_valid;
    logic        report;

    assign o_take  = i_item_valid && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;
    assign report  = i_item.last && (i_item.status == StOk);

    always_comb begin
        n_id    = r_id;
        n_node  = r_node;
        n_flags = r_flags;
        n_tlen  = r_tlen;
        n_klen  = r_klen;
        n_vlen  = r_vlen;
        unique case (i_item.kind)
            KIND_OTHER: begin
            end
            KIND_FLAGS: n_flags = i_item.data_byte;
            KIND_OPID:  n_id    = {r_id[55:0], i_item.data_byte};
            KIND_NODE:  n_node  = {r_node[23:0], i_item.data_byte};
            KIND_TLEN: begin
                n_tlen = i_item.data_byte;
                n_klen = 16'd0;
                n_vlen = 32'd0;
            end
            KIND_KLEN: begin
                n_klen = {r_klen[7:0], i_item.data_byte};
                n_vlen = 32'd0;
            end
            KIND_VLEN:  n_vlen  = {r_vlen[23:0], i_item.data_byte};
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_id        <= 64'd0;
            r_node      <= 32'd0;
            r_flags     <= 8'd0;
            r_tlen      <= 8'd0;
            r_klen      <= 16'd0;
            r_vlen      <= 32'd0;
        end else begin
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_take) begin
                if (i_item.last) begin
                    r_id    <= 64'd0;
                    r_node  <= 32'd0;
                    r_flags <= 8'd0;
                    r_tlen  <= 8'd0;
                    r_klen  <= 16'd0;
                    r_vlen  <= 32'd0;
                end else begin
                    r_id    <= n_id;
                    r_node  <= n_node;
                    r_flags <= n_flags;
                    r_tlen  <= n_tlen;
                    r_klen  <= n_klen;
                    r_vlen  <= n_vlen;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            o_segment       <= i_item.segment;
            o_payload_valid <= (i_item.segment != SegNone);
            o_payload_byte  <= (i_item.segment != SegNone) ? i_item.data_byte : 8'd0;
            o_message_done  <= i_item.last;
            o_status        <= i_item.status;
            o_operation_id  <= report ? n_id : 64'd0;
            o_node_number   <= report ? n_node : 32'd0;
            o_tombstone     <= report && ((n_flags & i_tombstone_mask) != 8'd0);
            o_topic_length  <= report ? n_tlen : 8'd0;
            o_key_length    <= report ? n_klen : 16'd0;
            o_value_length  <= report ? n_vlen : 32'd0;
        end
    end

endmodule

@@ hdl/cache_op_message_parser.sv @@
// Top level of the cache operation message parser: configuration registers and block wiring.
// Depends on cop_pkg, cop_front, cop_queue and cop_back.

// The parser takes one message byte per item and gives one result per item, at a sustained
// rate of one item per clock cycle while the output is not stalled. The front end classifies
// each byte into a two-entry queue at the accepting edge, and the back end moves it from the
// queue into the output register once that register is empty or not stalled, where it waits
// for as long as the output is stalled. The input stalls only when the queue is full. The
// status is reported on the result of the byte marked end of message; header fields, lengths
// and tombstone only when that status is OK. After that byte the parse starts afresh.
module cache_op_message_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cop_pkg::AddrWidth-1:0] paddr,
    input  logic [cop_pkg::DataWidth-1:0] pwdata,
    output logic [cop_pkg::DataWidth-1:0] prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_end_of_message,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_segment,
    output logic [7:0]                    o_payload_byte,
    output logic                          o_payload_valid,
    output logic                          o_message_done,
    output logic [1:0]                    o_status,
    output logic [63:0]                   o_operation_id,
    output logic [31:0]                   o_node_number,
    output logic                          o_tombstone,
    output logic [7:0]                    o_topic_length,
    output logic [15:0]                   o_key_length,
    output logic [31:0]                   o_value_length
);
    import cop_pkg::*;

    logic [7:0] r_expected_version;
    logic [7:0] r_tombstone_mask;
    logic       cfg_write;
    logic       push, full, take, q_valid;
    t_item      front_item, queue_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_version <= ExpectedVersionReset;
            r_tombstone_mask   <= TombstoneMaskReset;
        end else if (cfg_write) begin
            if (paddr[2] == RegExpectedVersion) begin
                r_expected_version <= pwdata[7:0];
            end else begin
                r_tombstone_mask <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == RegExpectedVersion) begin
            prdata = {24'd0, r_expected_version};
        end else begin
            prdata = {24'd0, r_tombstone_mask};
        end
    end

    cop_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_data_byte        (i_data_byte),
        .i_end_of_message   (i_end_of_message),
        .i_expected_version (r_expected_version),
        .i_full             (full),
        .o_push             (push),
        .o_item             (front_item)
    );

    cop_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (take),
        .o_valid (q_valid),
        .o_item  (queue_item)
    );

    cop_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (q_valid),
        .i_item           (queue_item),
        .o_take           (take),
        .i_tombstone_mask (r_tombstone_mask),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_segment        (o_segment),
        .o_payload_byte   (o_payload_byte),
        .o_payload_valid  (o_payload_valid),
        .o_message_done   (o_message_done),
        .o_status         (o_status),
        .o_operation_id   (o_operation_id),
        .o_node_number    (o_node_number),
        .o_tombstone      (o_tombstone),
        .o_topic_length   (o_topic_length),
        .o_key_length     (o_key_length),
        .o_value_length   (o_value_length)
    );

endmodule
